// ===== hw/rtl/sinusoidal_position_encoding_adder_assert.svh =====
`ifndef SINUSOIDAL_POSITION_ENCODING_ADDER_ASSERT_SVH
`define SINUSOIDAL_POSITION_ENCODING_ADDER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SPEA_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SPEA_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/spea_pkg.sv =====
package spea_pkg;

	localparam int SPEA_DIM           = 512;
	localparam int SPEA_CORDIC_STAGES = 18;
	localparam int SPEA_QUEUE_DEPTH   = 4;

	localparam int VALUE_W     = 32;
	localparam int POS_W       = 16;
	localparam int FREQ_W      = 40;
	localparam int FREQ_HALF_W = 20;
	localparam int CX_W        = 34;
	localparam int ROUND_SH    = 14;
	localparam int ENC_W       = CX_W - ROUND_SH;
	localparam int EXP_TERMS   = 24;

	localparam logic [POS_W-1:0] POS_LIMIT_RESET = 16'd512;
	localparam logic [POS_W-1:0] POS_MAX         = 16'hFFFF;

	localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

	localparam logic [63:0] Q60_ONE    = 64'h1000_0000_0000_0000;
	localparam logic [63:0] LN2_Q60    = 64'h0B17_217F_7D1C_F79B;
	localparam logic [63:0] LN10_Q60   = 64'h24D7_6377_6AAA_2B06;
	localparam logic [63:0] INV2PI_Q60 = 64'h028B_E60D_B939_1055;

	localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sh0_26DD_3B6A;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      sentence_end;
		logic                      past;
		logic                      odd;
	} spea_tag_t;

	localparam int TAG_W = $bits(spea_tag_t);

	// (a * b) >> 60, truncated to 64 bits
	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// atan(2^-k) in turns, 40 fraction bits, truncated
	function automatic logic signed [FREQ_W-1:0] atan_turns(input int k);
		logic [63:0] p;
		logic [63:0] acc;
		logic [63:0] term;
		int          j;
		if (k == 0) begin
			return FREQ_W'(64'd1 << 37);
		end
		p   = Q60_ONE >> k;
		acc = '0;
		j   = 0;
		while (p != 0) begin
			term = p / 64'(2 * j + 1);
			if (j[0]) begin
				acc = acc - term;
			end else begin
				acc = acc + term;
			end
			p = p >> (2 * k);
			j = j + 1;
		end
		return FREQ_W'(mul_q60(acc, INV2PI_Q60) >> 20);
	endfunction

endpackage

// ===== hw/rtl/spea_front.sv =====
`include "sinusoidal_position_encoding_adder_assert.svh"

module spea_front
	import spea_pkg::*;
#(
	parameter int DIM = SPEA_DIM
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [POS_W-1:0]                   cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [VALUE_W-1:0]          element_value,
	input  logic                               sentence_end,
	input  logic                               q_full,
	output logic                               push,
	output spea_tag_t                          push_tag,
	output logic [$clog2(DIM)-2:0]             push_addr,
	output logic [POS_W-1:0]                   push_pos
);

	localparam int IDX_W = $clog2(DIM);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

	logic [IDX_W-1:0] idx_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] limit_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign push      = in_valid && !q_full;

	always_comb begin
		push_tag.value        = element_value;
		push_tag.sentence_end = sentence_end;
		push_tag.past         = pos_q >= limit_q;
		push_tag.odd          = idx_q[0];
		push_addr             = idx_q[IDX_W-1:1];
		push_pos              = pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= POS_LIMIT_RESET;
			idx_q   <= '0;
			pos_q   <= '0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (push) begin
				if (sentence_end) begin
					idx_q <= '0;
					pos_q <= '0;
				end else if (idx_q == IDX_LAST) begin
					idx_q <= '0;
					// hold at the top count
					if (pos_q != POS_MAX) begin
						pos_q <= pos_q + 1'b1;
					end
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	`SPEA_NEXT(a_end_clears, push && sentence_end, idx_q == '0 && pos_q == '0, "counters not cleared after sentence end")
	`SPEA_IMPL(a_idx_range, 1'b1, idx_q <= IDX_LAST, "element index out of range")
	`SPEA_NEXT(a_pos_monotone, push && !sentence_end, pos_q >= $past(pos_q), "word position went backwards")

endmodule

// ===== hw/rtl/spea_queue.sv =====
module spea_queue
	import spea_pkg::*;
#(
	parameter int W     = TAG_W,
	parameter int DEPTH = SPEA_QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] head_data,
	output logic         empty,
	output logic         full
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign empty     = count_q == '0;
	assign full      = count_q == CNT_FULL;
	assign head_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/spea_cordic.sv =====
module spea_cordic
	import spea_pkg::*;
#(
	parameter int STAGES = SPEA_CORDIC_STAGES,
	parameter int SIDE_W = TAG_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [FREQ_W-1:0] in_z,
	input  logic [SIDE_W-1:0]        in_side,
	output logic                     out_valid,
	output logic signed [CX_W-1:0]   out_x,
	output logic signed [CX_W-1:0]   out_y,
	output logic [SIDE_W-1:0]        out_side
);

	logic signed [CX_W-1:0]   x_sk    [STAGES];
	logic signed [CX_W-1:0]   y_sk    [STAGES];
	logic signed [FREQ_W-1:0] z_sk    [STAGES];
	logic [SIDE_W-1:0]        side_sk [STAGES];
	logic                     valid_sk [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		localparam logic signed [FREQ_W-1:0] ATAN = atan_turns(k);

		logic signed [CX_W-1:0]   xi;
		logic signed [CX_W-1:0]   yi;
		logic signed [FREQ_W-1:0] zi;
		logic [SIDE_W-1:0]        si;
		logic                     vi;

		if (k == 0) begin : g_head
			assign xi = CORDIC_GAIN;
			assign yi = '0;
			assign zi = in_z;
			assign si = in_side;
			assign vi = in_valid;
		end else begin : g_tail
			assign xi = x_sk[k-1];
			assign yi = y_sk[k-1];
			assign zi = z_sk[k-1];
			assign si = side_sk[k-1];
			assign vi = valid_sk[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sk[k] <= 1'b0;
			end else if (en) begin
				valid_sk[k] <= vi;
			end
		end

		// rotate towards zero residual angle
		always_ff @(posedge clk) begin
			if (en) begin
				side_sk[k] <= si;
				if (!zi[FREQ_W-1]) begin
					x_sk[k] <= xi - (yi >>> k);
					y_sk[k] <= yi + (xi >>> k);
					z_sk[k] <= zi - ATAN;
				end else begin
					x_sk[k] <= xi + (yi >>> k);
					y_sk[k] <= yi - (xi >>> k);
					z_sk[k] <= zi + ATAN;
				end
			end
		end
	end

	assign out_valid = valid_sk[STAGES-1];
	assign out_x     = x_sk[STAGES-1];
	assign out_y     = y_sk[STAGES-1];
	assign out_side  = side_sk[STAGES-1];

endmodule

// ===== hw/rtl/spea_back.sv =====
`include "sinusoidal_position_encoding_adder_assert.svh"

module spea_back
	import spea_pkg::*;
#(
	parameter int DIM           = SPEA_DIM,
	parameter int CORDIC_STAGES = SPEA_CORDIC_STAGES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	input  spea_tag_t                 q_tag,
	input  logic [$clog2(DIM)-2:0]    q_addr,
	input  logic [POS_W-1:0]          q_pos,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] encoded_value,
	output logic                      sentence_end_out,
	output logic                      past_limit,
	output logic                      saturated
);

	localparam int HALF_DIM = (DIM + 1) / 2;
	localparam int MUL_W    = POS_W + FREQ_HALF_W;
	localparam int SIDE_W   = TAG_W + 2;

	localparam logic [63:0] LN10000 = LN10_Q60 << 2;
	localparam logic [63:0] LN_QUO  = LN10000 / DIM;
	localparam logic [63:0] LN_REM  = LN10000 % DIM;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// 10000^(-2k/DIM) / (2*pi) in turns per word, 40 fraction bits
	function automatic logic [FREQ_W-1:0] freq_entry(input int k);
		logic [63:0] m;
		logic [63:0] x;
		logic [63:0] n;
		logic [63:0] f;
		logic [63:0] s;
		logic [63:0] t;
		int          j;
		m = 64'(2 * k);
		x = LN_QUO * m + (LN_REM * m) / DIM;
		n = x / LN2_Q60;
		f = x - n * LN2_Q60;
		s = Q60_ONE;
		t = Q60_ONE;
		for (j = 1; j <= EXP_TERMS; j++) begin
			t = mul_q60(t, f) / 64'(j);
			if (j[0]) begin
				s = s - t;
			end else begin
				s = s + t;
			end
		end
		s = (n < 64) ? (s >> n) : '0;
		return FREQ_W'(mul_q60(s, INV2PI_Q60) >> 20);
	endfunction

	logic [FREQ_W-1:0] freq_rom [HALF_DIM];

	for (genvar k = 0; k < HALF_DIM; k++) begin : g_rom
		localparam logic [FREQ_W-1:0] ENTRY = freq_entry(k);
		assign freq_rom[k] = ENTRY;
	end

	logic en;

	logic                     valid_s1;
	logic [FREQ_W-1:0]        freq_s1;
	logic [POS_W-1:0]         pos_s1;
	spea_tag_t                tag_s1;

	logic                     valid_s2;
	logic [MUL_W-1:0]         prod_lo_s2;
	logic [FREQ_HALF_W-1:0]   prod_hi_s2;
	spea_tag_t                tag_s2;

	logic                     valid_s3;
	logic [FREQ_W-1:0]        phase_s3;
	spea_tag_t                tag_s3;

	logic                     valid_s4;
	logic [1:0]               quad_s4;
	logic signed [FREQ_W-1:0] z_s4;
	spea_tag_t                tag_s4;

	logic                     valid_c;
	logic signed [CX_W-1:0]   x_c;
	logic signed [CX_W-1:0]   y_c;
	logic [SIDE_W-1:0]        side_c;
	spea_tag_t                tag_c;
	logic [1:0]               quad_c;

	logic                     valid_s5;
	logic signed [ENC_W-1:0]  enc_s5;
	spea_tag_t                tag_s5;

	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] encoded_q;
	logic                      end_q;
	logic                      past_limit_q;
	logic                      saturated_q;

	logic [MUL_W-1:0]         mul_lo;
	logic [MUL_W-1:0]         mul_hi;
	logic [FREQ_W-1:0]        quad_round;
	logic [1:0]               quad;
	logic signed [CX_W-1:0]   cos_v;
	logic signed [CX_W-1:0]   sin_v;
	logic signed [CX_W-1:0]   sel_v;
	logic signed [CX_W-1:0]   rnd_v;
	logic signed [VALUE_W:0]  sum;
	logic signed [VALUE_W-1:0] sum_clamped;
	logic                      sum_ovf;

	// freeze the whole pipeline while a finished word waits
	assign en  = !out_valid_q || !out_stall;
	assign pop = en && !q_empty;

	assign mul_lo = MUL_W'(pos_s1) * MUL_W'(freq_s1[FREQ_HALF_W-1:0]);
	assign mul_hi = MUL_W'(pos_s1) * MUL_W'(freq_s1[FREQ_W-1:FREQ_HALF_W]);

	// nearest quarter turn, residue within an eighth of a turn
	assign quad_round = phase_s3 + FREQ_W'(64'd1 << 37);
	assign quad       = quad_round[FREQ_W-1:FREQ_W-2];

	assign tag_c  = spea_tag_t'(side_c[TAG_W-1:0]);
	assign quad_c = side_c[SIDE_W-1:TAG_W];

	always_comb begin
		case (quad_c)
			QUAD_0: begin
				cos_v = x_c;
				sin_v = y_c;
			end
			QUAD_1: begin
				cos_v = -y_c;
				sin_v = x_c;
			end
			QUAD_2: begin
				cos_v = -x_c;
				sin_v = -y_c;
			end
			QUAD_3: begin
				cos_v = y_c;
				sin_v = -x_c;
			end
			default: begin
				cos_v = x_c;
				sin_v = y_c;
			end
		endcase
		sel_v = tag_c.odd ? cos_v : sin_v;
		rnd_v = (sel_v + CX_W'(1 << (ROUND_SH - 1))) >>> ROUND_SH;
	end

	always_comb begin
		sum = $signed({tag_s5.value[VALUE_W-1], tag_s5.value})
			+ $signed({{(VALUE_W + 1 - ENC_W){enc_s5[ENC_W-1]}}, enc_s5});
		sum_ovf = sum[VALUE_W] != sum[VALUE_W-1];
		if (sum_ovf) begin
			sum_clamped = sum[VALUE_W] ? VALUE_MIN : VALUE_MAX;
		end else begin
			sum_clamped = sum[VALUE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= !q_empty;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			valid_s5    <= valid_c;
			out_valid_q <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			freq_s1    <= freq_rom[q_addr];
			pos_s1     <= q_pos;
			tag_s1     <= q_tag;

			prod_lo_s2 <= mul_lo;
			prod_hi_s2 <= mul_hi[FREQ_HALF_W-1:0];
			tag_s2     <= tag_s1;

			phase_s3   <= FREQ_W'(prod_lo_s2) + {prod_hi_s2, {FREQ_HALF_W{1'b0}}};
			tag_s3     <= tag_s2;

			quad_s4    <= quad;
			z_s4       <= $signed(phase_s3 - {quad, {(FREQ_W - 2){1'b0}}});
			tag_s4     <= tag_s3;

			enc_s5     <= rnd_v[ENC_W-1:0];
			tag_s5     <= tag_c;

			end_q      <= tag_s5.sentence_end;
			past_limit_q <= tag_s5.past;
			if (tag_s5.past) begin
				encoded_q   <= tag_s5.value;
				saturated_q <= 1'b0;
			end else begin
				encoded_q   <= sum_clamped;
				saturated_q <= sum_ovf;
			end
		end
	end

	spea_cordic #(
		.STAGES (CORDIC_STAGES),
		.SIDE_W (SIDE_W)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s4),
		.in_z      (z_s4),
		.in_side   ({quad_s4, tag_s4}),
		.out_valid (valid_c),
		.out_x     (x_c),
		.out_y     (y_c),
		.out_side  (side_c)
	);

	assign out_valid        = out_valid_q;
	assign encoded_value    = encoded_q;
	assign sentence_end_out = end_q;
	assign past_limit       = past_limit_q;
	assign saturated        = saturated_q;

	`SPEA_NEXT(a_hold_on_stall, !en, $stable(valid_s5) && $stable(out_valid_q), "pipeline moved while output stalled")
	`SPEA_IMPL(a_past_not_sat, out_valid_q && past_limit_q, !saturated_q, "passed-through word flagged saturated")
	`SPEA_IMPL(a_sat_extreme, out_valid_q && saturated_q, encoded_q == VALUE_MAX || encoded_q == VALUE_MIN, "saturated word not at range limit")

endmodule

// ===== hw/rtl/sinusoidal_position_encoding_adder.sv =====
// Adds a sinusoidal position code to a stream of Q16.16 word-vector elements.
// Input channel (in_valid / in_stall): one element per transfer, DIM elements per
// word, sentence_end on the last element of a sentence; the element index and
// word position count themselves and return to zero after sentence_end.
// Output channel (out_valid / out_stall): encoded_value with sentence_end_out,
// past_limit and saturated, one result per input element, in order.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes position_limit;
// cfg_ready is always high. Write it only while the block is empty.
// Throughput: one element per cycle while out_stall holds no result. From
// acceptance to out_valid an element passes the ROM read, the split 16x40
// phase multiply, the quadrant stage and the CORDIC pipeline.
// A QUEUE_DEPTH-entry queue sits between the counters and the arithmetic;
// in_stall rises only when it is full. While out_stall holds a result, the
// arithmetic pipeline freezes and the queue keeps taking elements.
// Reset: counters to zero, position_limit to 512, pipeline and queue empty;
// the frequency ROM is constant, so no start-up sweep is needed.
module sinusoidal_position_encoding_adder
	import spea_pkg::*;
#(
	parameter int DIM           = SPEA_DIM,
	parameter int CORDIC_STAGES = SPEA_CORDIC_STAGES,
	parameter int QUEUE_DEPTH   = SPEA_QUEUE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [POS_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [VALUE_W-1:0] element_value,
	input  logic                      sentence_end,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] encoded_value,
	output logic                      sentence_end_out,
	output logic                      past_limit,
	output logic                      saturated
);

	localparam int ADDR_W = $clog2(DIM) - 1;
	localparam int ITEM_W = TAG_W + ADDR_W + POS_W;

	logic              push;
	spea_tag_t         push_tag;
	logic [ADDR_W-1:0] push_addr;
	logic [POS_W-1:0]  push_pos;
	logic              q_full;
	logic              q_empty;
	logic              pop;
	logic [ITEM_W-1:0] head_data;
	spea_tag_t         q_tag;
	logic [ADDR_W-1:0] q_addr;
	logic [POS_W-1:0]  q_pos;

	assign q_tag  = spea_tag_t'(head_data[ITEM_W-1:ADDR_W+POS_W]);
	assign q_addr = head_data[ADDR_W+POS_W-1:POS_W];
	assign q_pos  = head_data[POS_W-1:0];

	spea_front #(
		.DIM (DIM)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.element_value (element_value),
		.sentence_end  (sentence_end),
		.q_full        (q_full),
		.push          (push),
		.push_tag      (push_tag),
		.push_addr     (push_addr),
		.push_pos      (push_pos)
	);

	spea_queue #(
		.W     (ITEM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_tag, push_addr, push_pos}),
		.pop       (pop),
		.head_data (head_data),
		.empty     (q_empty),
		.full      (q_full)
	);

	spea_back #(
		.DIM           (DIM),
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_empty          (q_empty),
		.q_tag            (q_tag),
		.q_addr           (q_addr),
		.q_pos            (q_pos),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.encoded_value    (encoded_value),
		.sentence_end_out (sentence_end_out),
		.past_limit       (past_limit),
		.saturated        (saturated)
	);

endmodule
